// ----- hdl/slbs_pkg.sv -----
`default_nettype none
package slbs_pkg;

  localparam int SLOTS      = 1024;
  localparam int NUM_STACKS = 3;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int HEAD_W = $clog2(NUM_STACKS + 1);
  localparam int CNT_W  = IDX_W + 1;

  // the free list sits after the stacks in the head table
  localparam logic [HEAD_W-1:0] FREE_LIST = HEAD_W'(NUM_STACKS);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADSEL = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } ptr_t;

endpackage
`default_nettype wire

// ----- hdl/slbs_ram.sv -----
`default_nettype none
module slbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hdl/shared_buffer_linked_stacks.sv -----
`default_nettype none
// Three LIFO stacks sharing one 1024-slot store through linked lists, with a
// free list chaining every unused slot. Raise start with in_cmd (push or pop),
// in_stack_select and in_push_value while busy is low; that edge accepts the
// transaction. busy is then high for one cycle while the slot's link and value
// are read from the synchronous memories, and in the cycle after that the
// result appears on out_pop_data / out_status, flagged by out_valid for
// exactly one cycle. The receiver cannot stall the block, and no new
// transaction is accepted while busy is high: the link memory read must
// return before a list head can be updated. A pop from an empty stack
// (status 1), a push with no free slot (status 2) or a stack_select naming
// no stack (status 3) changes nothing and returns zero data. After reset no
// clearing pass is needed: a fill count marks the slots never yet allocated,
// whose links are implied, so the block takes transactions straight away.
module shared_buffer_linked_stacks
  import slbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_cmd,
  input  wire logic [1:0]            in_stack_select,
  input  wire logic signed [31:0]    in_push_value,
  output logic                       out_valid,
  output logic signed [31:0]         out_pop_data,
  output logic [1:0]                 out_status
);

  // list heads: the stacks first, the free list last
  ptr_t heads_r [NUM_STACKS+1];
  ptr_t heads_nxt [NUM_STACKS+1];

  // slots below fresh_r have never been allocated and still link to slot-1
  logic [CNT_W-1:0] fresh_r, fresh_nxt;

  logic busy_r, busy_nxt;
  logic out_valid_r, out_valid_nxt;

  // transaction held across the memory read
  logic                  cmd_r;
  logic [HEAD_W-1:0]     sel_r;
  logic [IDX_W-1:0]      slot_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [1:0]            pend_status_r;

  logic signed [31:0] out_pop_data_r, out_pop_data_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic                  accept;
  logic [HEAD_W-1:0]     in_sel;
  logic [IDX_W-1:0]      slot_sel;
  logic [1:0]            status_sel;

  // memory ports
  logic                  link_we;
  ptr_t                  link_wdata;
  logic [$bits(ptr_t)-1:0] link_rdata;
  ptr_t                  link_rd;
  ptr_t                  link_eff;
  logic                  val_we;
  logic [DATA_WIDTH-1:0] val_rdata;

  assign accept = start && !busy_r;
  assign in_sel = HEAD_W'(in_stack_select);

  // pick the slot to be unlinked and check for the error cases
  always_comb begin
    if (in_cmd == CMD_PUSH) begin
      slot_sel = heads_r[FREE_LIST].idx;
    end else begin
      slot_sel = heads_r[in_sel].idx;
    end
    if (32'(in_stack_select) >= NUM_STACKS) begin
      status_sel = ST_BADSEL;
    end else if (in_cmd == CMD_PUSH && !heads_r[FREE_LIST].valid) begin
      status_sel = ST_FULL;
    end else if (in_cmd == CMD_POP && !heads_r[in_sel].valid) begin
      status_sel = ST_EMPTY;
    end else begin
      status_sel = ST_OK;
    end
  end

  slbs_ram #(
    .WIDTH ($bits(ptr_t)),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (slot_r),
    .wr_data (link_wdata),
    .rd_addr (slot_sel),
    .rd_data (link_rdata)
  );

  slbs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SLOTS)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (slot_r),
    .wr_data (val_r),
    .rd_addr (slot_sel),
    .rd_data (val_rdata)
  );

  assign link_rd = link_rdata;

  // an untouched slot links to the one below it; slot 0 ends the chain
  always_comb begin
    if ({1'b0, slot_r} < fresh_r) begin
      link_eff.valid = (slot_r != '0);
      link_eff.idx   = slot_r - IDX_W'(1);
    end else begin
      link_eff = link_rd;
    end
  end

  // busy cycle: relink the slot and update the heads
  always_comb begin
    heads_nxt        = heads_r;
    fresh_nxt        = fresh_r;
    busy_nxt         = accept;
    out_valid_nxt    = busy_r;
    out_pop_data_nxt = out_pop_data_r;
    out_status_nxt   = out_status_r;
    link_we          = 1'b0;
    link_wdata       = heads_r[FREE_LIST];
    val_we           = 1'b0;

    if (busy_r) begin
      out_status_nxt   = pend_status_r;
      out_pop_data_nxt = '0;
      if (pend_status_r == ST_OK) begin
        link_we = 1'b1;
        if (cmd_r == CMD_PUSH) begin
          // take the free head, push it onto the chosen stack
          val_we                = 1'b1;
          link_wdata            = heads_r[sel_r];
          heads_nxt[FREE_LIST]  = link_eff;
          heads_nxt[sel_r]      = '{valid: 1'b1, idx: slot_r};
          if ({1'b0, slot_r} < fresh_r) begin
            fresh_nxt = {1'b0, slot_r};
          end
        end else begin
          // unlink the stack head, return the slot to the free list
          link_wdata            = heads_r[FREE_LIST];
          heads_nxt[sel_r]      = link_eff;
          heads_nxt[FREE_LIST]  = '{valid: 1'b1, idx: slot_r};
          out_pop_data_nxt      = 32'(signed'(val_rdata));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fresh_r     <= CNT_W'(SLOTS);
      for (int i = 0; i < NUM_STACKS; i++) begin
        heads_r[i] <= '{valid: 1'b0, idx: '0};
      end
      heads_r[FREE_LIST] <= '{valid: 1'b1, idx: IDX_W'(SLOTS - 1)};
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      fresh_r     <= fresh_nxt;
      heads_r     <= heads_nxt;
    end
  end

  // payload: hold the accepted transaction and the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r         <= in_cmd;
      sel_r         <= in_sel;
      slot_r        <= slot_sel;
      val_r         <= in_push_value[DATA_WIDTH-1:0];
      pend_status_r <= status_sel;
    end
    out_pop_data_r <= out_pop_data_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign busy         = busy_r;
  assign out_valid    = out_valid_r;
  assign out_pop_data = out_pop_data_r;
  assign out_status   = out_status_r;

endmodule
`default_nettype wire
